// File: rtl/core/tw_rtc_pkg.sv
// ----------------------------------------------------------------------------
// tw_rtc_pkg
// Shared types, codes and conversion helpers for the three-wire RTC master.
// ----------------------------------------------------------------------------
package tw_rtc_pkg;

  // stream widths (tdata fields packed from bit 0, padded to whole bytes)
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 16;

  // transaction opcodes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // bit counts for a write (command + data) and a read (command + reply)
  localparam logic [4:0] WR_BITS  = 5'd16;
  localparam logic [4:0] CMD_BITS = 5'd8;
  localparam logic [4:0] RD_BITS  = 5'd16;

  // divide by ten as multiply by reciprocal, exact for 8-bit values
  localparam logic [15:0] DIV10_RECIP = 16'd205;
  localparam int          DIV10_SHIFT = 11;
  localparam logic [7:0]  DEC_BASE    = 8'd10;

  // decimal to packed bcd, result cut to 8 bits
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [7:0]  quo;
    logic [7:0]  rem;
    logic [11:0] packed_val;
    prod       = 16'(v) * DIV10_RECIP;
    quo        = 8'(prod >> DIV10_SHIFT);
    rem        = v - 8'(quo * DEC_BASE);
    packed_val = {quo, 4'b0000} | {8'b0, rem[3:0]};
    return packed_val[7:0];
  endfunction

  // packed bcd to decimal: high nibble times ten plus low nibble
  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    return 8'({4'b0000, b[7:4]} * DEC_BASE) + {4'b0000, b[3:0]};
  endfunction

endpackage

// File: rtl/core/three_wire_rtc_access_master.sv
// ----------------------------------------------------------------------------
// three_wire_rtc_access_master
// Bit-banged three-wire serial master for an RTC chip, one pin phase per tick.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / tuser / tlast
//  s_*     | in        | tdata: command_byte, write_value, data_line_in
//          |           | tuser: opcode
//  m_*     | out       | tdata: enable_line, clock_line, data_out, data_drive,
//          |           |        read_value; tlast: done_res
//
//  One input transaction per clock cycle while s_tready is high; its result is
//  registered and shown on the next cycle. A start command changes state only
//  and gives no result; each tick gives exactly one result. s_tready is low only
//  while a result is held in the output register and m_tready is low. rst is
//  synchronous and returns the sequencer to idle with all pins low.
// ----------------------------------------------------------------------------
module three_wire_rtc_access_master
  import tw_rtc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // [7:0] command_byte, [15:8] write_value, [16] data_line_in, [23:17] zero
  input  logic [S_TDATA_W-1:0] s_tdata,
  // [1:0] opcode
  input  logic [S_TUSER_W-1:0] s_tuser,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [0] enable_line, [1] clock_line, [2] data_out, [3] data_drive,
  // [11:4] read_value, [15:12] zero
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready
);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_EN_LOW   = 4'd1,
    PH_CLK_LOW  = 4'd2,
    PH_EN_HIGH  = 4'd3,
    PH_TX_DRIVE = 4'd4,
    PH_TX_CLK   = 4'd5,
    PH_WR_END   = 4'd6,
    PH_RX_SMPL  = 4'd7,
    PH_RX_CLK   = 4'd8,
    PH_TR_EN    = 4'd9,
    PH_TR_CLKL  = 4'd10,
    PH_TR_CLKH  = 4'd11,
    PH_TR_DAT0  = 4'd12,
    PH_RD_END   = 4'd13
  } phase_t;

  // input fields
  opcode_t    op;
  logic [7:0] command_byte;
  logic [7:0] write_value;
  logic       data_line_in;

  assign op           = opcode_t'(s_tuser[1:0]);
  assign command_byte = s_tdata[7:0];
  assign write_value  = s_tdata[15:8];
  assign data_line_in = s_tdata[16];

  // sequencer state
  logic        busy, busy_next;
  logic        is_read, is_read_next;
  logic [15:0] send_shift, send_shift_next;
  logic [7:0]  recv_shift, recv_shift_next;
  logic [4:0]  bit_count, bit_count_next;
  phase_t      phase, phase_next;
  logic        pin_en, pin_en_next;
  logic        pin_clk, pin_clk_next;
  logic        pin_dat, pin_dat_next;
  logic        pin_drv, pin_drv_next;
  logic        done_next;
  logic [7:0]  read_value_next;
  logic [4:0]  bit_count_inc;

  // result register
  logic       out_en, out_clk, out_dat, out_drv, out_done;
  logic [7:0] out_rv;

  logic s_acc;
  logic is_tick;

  assign s_tready = !m_tvalid || m_tready;
  assign s_acc    = s_tvalid && s_tready;
  assign is_tick  = (op == OP_TICK);
  assign bit_count_inc = bit_count + 5'd1;

  // next state for one accepted transaction
  always_comb begin
    busy_next       = busy;
    is_read_next    = is_read;
    send_shift_next = send_shift;
    recv_shift_next = recv_shift;
    bit_count_next  = bit_count;
    phase_next      = phase;
    pin_en_next     = pin_en;
    pin_clk_next    = pin_clk;
    pin_dat_next    = pin_dat;
    pin_drv_next    = pin_drv;
    done_next       = 1'b0;
    read_value_next = 8'd0;
    if (op == OP_WRITE || op == OP_READ) begin
      // start is taken only when idle
      if (!busy) begin
        busy_next       = 1'b1;
        is_read_next    = (op == OP_READ);
        send_shift_next = (op == OP_READ) ? {8'd0, command_byte}
                                          : {to_bcd(write_value), command_byte};
        recv_shift_next = 8'd0;
        bit_count_next  = 5'd0;
        phase_next      = PH_EN_LOW;
      end
    end else if (is_tick) begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_EN_LOW: begin
          pin_en_next = 1'b0;
          phase_next  = PH_CLK_LOW;
        end
        PH_CLK_LOW: begin
          pin_clk_next = 1'b0;
          phase_next   = PH_EN_HIGH;
        end
        PH_EN_HIGH: begin
          pin_en_next = 1'b1;
          phase_next  = PH_TX_DRIVE;
        end
        PH_TX_DRIVE: begin
          pin_clk_next    = 1'b0;
          pin_dat_next    = send_shift[0];
          pin_drv_next    = 1'b1;
          send_shift_next = send_shift >> 1;
          phase_next      = PH_TX_CLK;
        end
        PH_TX_CLK: begin
          pin_clk_next   = 1'b1;
          bit_count_next = bit_count_inc;
          if (is_read && bit_count_inc >= CMD_BITS) begin
            phase_next = PH_RX_SMPL;
          end else if (!is_read && bit_count_inc >= WR_BITS) begin
            phase_next = PH_WR_END;
          end else begin
            phase_next = PH_TX_DRIVE;
          end
        end
        PH_WR_END: begin
          pin_en_next = 1'b0;
          done_next   = 1'b1;
          busy_next   = 1'b0;
          phase_next  = PH_IDLE;
        end
        PH_RX_SMPL: begin
          pin_clk_next    = 1'b0;
          pin_drv_next    = 1'b0;
          recv_shift_next = {data_line_in, recv_shift[7:1]};
          phase_next      = PH_RX_CLK;
        end
        PH_RX_CLK: begin
          pin_clk_next   = 1'b1;
          bit_count_next = bit_count_inc;
          phase_next     = (bit_count_inc >= RD_BITS) ? PH_TR_EN : PH_RX_SMPL;
        end
        PH_TR_EN: begin
          pin_en_next = 1'b0;
          phase_next  = PH_TR_CLKL;
        end
        PH_TR_CLKL: begin
          pin_clk_next = 1'b0;
          phase_next   = PH_TR_CLKH;
        end
        PH_TR_CLKH: begin
          pin_clk_next = 1'b1;
          phase_next   = PH_TR_DAT0;
        end
        PH_TR_DAT0: begin
          pin_dat_next = 1'b0;
          pin_drv_next = 1'b1;
          phase_next   = PH_RD_END;
        end
        PH_RD_END: begin
          pin_dat_next    = 1'b1;
          pin_drv_next    = 1'b1;
          read_value_next = from_bcd(recv_shift);
          done_next       = 1'b1;
          busy_next       = 1'b0;
          phase_next      = PH_IDLE;
        end
        default: begin
          busy_next  = 1'b0;
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      is_read    <= 1'b0;
      send_shift <= 16'd0;
      recv_shift <= 8'd0;
      bit_count  <= 5'd0;
      phase      <= PH_IDLE;
      pin_en     <= 1'b0;
      pin_clk    <= 1'b0;
      pin_dat    <= 1'b0;
      pin_drv    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (s_acc) begin
        busy       <= busy_next;
        is_read    <= is_read_next;
        send_shift <= send_shift_next;
        recv_shift <= recv_shift_next;
        bit_count  <= bit_count_next;
        phase      <= phase_next;
        pin_en     <= pin_en_next;
        pin_clk    <= pin_clk_next;
        pin_dat    <= pin_dat_next;
        pin_drv    <= pin_drv_next;
      end
      if (s_acc && is_tick) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each tick transaction
  always_ff @(posedge clk) begin
    if (s_acc && is_tick) begin
      out_en   <= pin_en_next;
      out_clk  <= pin_clk_next;
      out_dat  <= pin_drv_next & pin_dat_next;
      out_drv  <= pin_drv_next;
      out_done <= done_next;
      out_rv   <= read_value_next;
    end
  end

  assign m_tdata = {4'b0000, out_rv, out_drv, out_dat, out_clk, out_en};
  assign m_tlast = out_done;

  // idle phase and busy flag always agree
  a_busy_phase: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) == !busy)
    else $error("busy flag and phase disagree");

  // bit counter never runs past a full transfer
  a_bit_count: assert property (@(posedge clk) disable iff (rst)
    bit_count <= WR_BITS)
    else $error("bit counter out of range");

  // a final phase tick frees the sequencer
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    s_acc && is_tick && (phase == PH_WR_END || phase == PH_RD_END) |=> !busy)
    else $error("sequencer still busy after end of transfer");

  // read value only reported with the ending transaction
  a_rv_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> (m_tdata[11:4] == 8'd0))
    else $error("read value without done");

  // start commands never produce a result
  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    s_acc && !is_tick && m_tready |=> !m_tvalid)
    else $error("result produced by a non-tick transaction");

endmodule

// File: sim/tb_three_wire_rtc_access_master.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_wire_rtc_access_master
// Self-checking bench for the three-wire RTC master. A table of directed
// transactions covers idle ticks, ignored opcodes, starts while busy and full
// read and write transfers at the value extremes. A random phase follows,
// made mostly of complete transfers with random content. A line-level model
// in the bench predicts every result, and each output transaction is
// compared field by field. Both stream sides see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_three_wire_rtc_access_master;
  import tw_rtc_pkg::*;

  // sequencer phases, one phase step per tick
  typedef enum logic [3:0] {
    PH_IDLE          = 4'd0,
    PH_EN_LOW        = 4'd1,
    PH_CLK_LOW       = 4'd2,
    PH_EN_HIGH       = 4'd3,
    PH_BIT_LOW       = 4'd4,
    PH_BIT_HIGH      = 4'd5,
    PH_WR_END        = 4'd6,
    PH_RX_LOW        = 4'd7,
    PH_RX_HIGH       = 4'd8,
    PH_TAIL_EN       = 4'd9,
    PH_TAIL_CLK_LOW  = 4'd10,
    PH_TAIL_CLK_HIGH = 4'd11,
    PH_TAIL_DAT0     = 4'd12,
    PH_TAIL_DAT1     = 4'd13
  } rtc_phase_t;

  // line levels and flags carried by one output transaction
  typedef struct packed {
    logic       en;
    logic       sclk;
    logic       dout;
    logic       drv;
    logic       done;
    logic [7:0] rv;
  } line_t;

  // one directed row, repeated reps times; fixed rows carry their own result
  typedef struct packed {
    opcode_t    op;
    logic [7:0] cmd;
    logic [7:0] wv;
    logic       din;
    logic [7:0] reps;
    logic       fixed;
    line_t      lv;
  } stim_row_t;

  localparam logic [4:0] CMD_LEN      = 5'd8;
  localparam logic [4:0] WRITE_LEN    = 5'd16;
  localparam logic [4:0] READ_LEN     = 5'd16;
  localparam int         RAND_ITEMS   = 700;
  localparam int         LONG_HOLD    = 300;
  localparam int         PRESSURE_AT  = 400;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         N_ROWS       = 22;

  localparam line_t LV_ZERO       = '0;
  localparam line_t LV_AFTER_READ = '{en: 1'b0, sclk: 1'b1, dout: 1'b1, drv: 1'b1,
                                      done: 1'b0, rv: 8'd0};
  localparam line_t LV_READ_MAX   = '{en: 1'b0, sclk: 1'b1, dout: 1'b1, drv: 1'b1,
                                      done: 1'b1, rv: 8'd165};
  localparam line_t LV_READ_MIN   = '{en: 1'b0, sclk: 1'b1, dout: 1'b1, drv: 1'b1,
                                      done: 1'b1, rv: 8'd0};

  // directed transactions
  stim_row_t dir_rows [N_ROWS] = '{
    // idle ticks right after reset, lines at rest whatever the other fields
    '{OP_TICK,  8'h00, 8'h00,  1'b0, 8'd1,  1'b1, LV_ZERO},
    '{OP_TICK,  8'hFF, 8'hFF,  1'b1, 8'd1,  1'b1, LV_ZERO},
    // spare opcode is dropped
    '{OP_NONE,  8'hFF, 8'hFF,  1'b1, 8'd1,  1'b0, LV_ZERO},
    // write of 255, bcd value cut to 8 bits, with starts and spare opcode mid-way
    '{OP_WRITE, 8'h80, 8'd255, 1'b0, 8'd1,  1'b0, LV_ZERO},
    '{OP_READ,  8'h81, 8'h00,  1'b0, 8'd1,  1'b0, LV_ZERO},
    '{OP_TICK,  8'h00, 8'h00,  1'b1, 8'd10, 1'b0, LV_ZERO},
    '{OP_NONE,  8'h00, 8'h00,  1'b0, 8'd1,  1'b0, LV_ZERO},
    '{OP_WRITE, 8'h01, 8'd7,   1'b0, 8'd1,  1'b0, LV_ZERO},
    '{OP_TICK,  8'h00, 8'h00,  1'b0, 8'd26, 1'b0, LV_ZERO},
    // write of zero
    '{OP_WRITE, 8'h00, 8'd0,   1'b0, 8'd1,  1'b0, LV_ZERO},
    '{OP_TICK,  8'h00, 8'h00,  1'b1, 8'd36, 1'b0, LV_ZERO},
    // largest two-digit write
    '{OP_WRITE, 8'hFF, 8'd99,  1'b1, 8'd1,  1'b0, LV_ZERO},
    '{OP_TICK,  8'h00, 8'h00,  1'b0, 8'd36, 1'b0, LV_ZERO},
    // read with the line held high decodes to the largest value
    '{OP_READ,  8'h81, 8'h00,  1'b0, 8'd1,  1'b0, LV_ZERO},
    '{OP_TICK,  8'h00, 8'h00,  1'b1, 8'd39, 1'b0, LV_ZERO},
    '{OP_TICK,  8'h00, 8'h00,  1'b1, 8'd1,  1'b1, LV_READ_MAX},
    // idle tick keeps the trailing levels
    '{OP_TICK,  8'h00, 8'h00,  1'b0, 8'd1,  1'b1, LV_AFTER_READ},
    // read with the line held low decodes to zero
    '{OP_READ,  8'hFE, 8'hFF,  1'b1, 8'd1,  1'b0, LV_ZERO},
    '{OP_TICK,  8'hFF, 8'hFF,  1'b0, 8'd39, 1'b0, LV_ZERO},
    '{OP_TICK,  8'h00, 8'h00,  1'b0, 8'd1,  1'b1, LV_READ_MIN},
    // plain write to round off
    '{OP_WRITE, 8'h8E, 8'd59,  1'b0, 8'd1,  1'b0, LV_ZERO},
    '{OP_TICK,  8'h00, 8'h00,  1'b1, 8'd36, 1'b0, LV_ZERO}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;

  // line-level model state
  logic       rtc_busy = 1'b0;
  logic       rtc_is_read = 1'b0;
  logic [15:0] tx_shift = '0;
  logic [7:0] rx_shift = '0;
  logic [4:0] bit_cnt = '0;
  rtc_phase_t ph = PH_IDLE;
  logic       pin_en = 1'b0;
  logic       pin_sclk = 1'b0;
  logic       pin_dat = 1'b0;
  logic       pin_drv = 1'b0;

  line_t pending_levels [$];
  int    errors = 0;
  bit    tx_calm = 1'b0;
  bit    hold_req = 1'b0;

  three_wire_rtc_access_master u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    if (errors <= 40) begin
      $display("%0t ns mismatch: %s got %0d want %0d", $time, what, got, want);
    end
  endtask

  // advance the line-level model by one accepted transaction
  task automatic advance_sequencer(input opcode_t op, input logic [7:0] cmd,
                                   input logic [7:0] wv, input logic din,
                                   output bit produced, output bit took,
                                   output line_t lv);
    int         tens;
    logic [7:0] bcd;
    logic       done;
    logic [7:0] rv;
    produced = 1'b0;
    took     = 1'b0;
    lv       = '0;
    done     = 1'b0;
    rv       = '0;
    if (op == OP_WRITE || op == OP_READ) begin
      // a start only loads the transfer, and only when idle
      if (!rtc_busy) begin
        took        = 1'b1;
        tens        = wv / 10;
        bcd         = 8'((tens << 4) | (wv % 10));
        rtc_busy    = 1'b1;
        rtc_is_read = (op == OP_READ);
        tx_shift    = rtc_is_read ? {8'h00, cmd} : {bcd, cmd};
        rx_shift    = '0;
        bit_cnt     = '0;
        ph          = PH_EN_LOW;
      end
    end else if (op == OP_TICK) begin
      took     = 1'b1;
      produced = 1'b1;
      case (ph)
        PH_IDLE: begin
        end
        PH_EN_LOW: begin
          pin_en = 1'b0;
          ph     = PH_CLK_LOW;
        end
        PH_CLK_LOW: begin
          pin_sclk = 1'b0;
          ph       = PH_EN_HIGH;
        end
        PH_EN_HIGH: begin
          pin_en = 1'b1;
          ph     = PH_BIT_LOW;
        end
        PH_BIT_LOW: begin
          pin_sclk = 1'b0;
          pin_dat  = tx_shift[0];
          pin_drv  = 1'b1;
          tx_shift = tx_shift >> 1;
          ph       = PH_BIT_HIGH;
        end
        PH_BIT_HIGH: begin
          pin_sclk = 1'b1;
          bit_cnt  = bit_cnt + 5'd1;
          if (rtc_is_read && bit_cnt >= CMD_LEN) ph = PH_RX_LOW;
          else if (!rtc_is_read && bit_cnt >= WRITE_LEN) ph = PH_WR_END;
          else ph = PH_BIT_LOW;
        end
        PH_WR_END: begin
          pin_en   = 1'b0;
          done     = 1'b1;
          rtc_busy = 1'b0;
          ph       = PH_IDLE;
        end
        PH_RX_LOW: begin
          // line released, reply bits arrive lsb first
          pin_sclk = 1'b0;
          pin_drv  = 1'b0;
          rx_shift = {din, rx_shift[7:1]};
          ph       = PH_RX_HIGH;
        end
        PH_RX_HIGH: begin
          pin_sclk = 1'b1;
          bit_cnt  = bit_cnt + 5'd1;
          ph       = (bit_cnt >= READ_LEN) ? PH_TAIL_EN : PH_RX_LOW;
        end
        PH_TAIL_EN: begin
          pin_en = 1'b0;
          ph     = PH_TAIL_CLK_LOW;
        end
        PH_TAIL_CLK_LOW: begin
          pin_sclk = 1'b0;
          ph       = PH_TAIL_CLK_HIGH;
        end
        PH_TAIL_CLK_HIGH: begin
          pin_sclk = 1'b1;
          ph       = PH_TAIL_DAT0;
        end
        PH_TAIL_DAT0: begin
          pin_dat = 1'b0;
          pin_drv = 1'b1;
          ph      = PH_TAIL_DAT1;
        end
        PH_TAIL_DAT1: begin
          pin_dat  = 1'b1;
          pin_drv  = 1'b1;
          rv       = 8'(rx_shift[7:4] * 10 + rx_shift[3:0]);
          done     = 1'b1;
          rtc_busy = 1'b0;
          ph       = PH_IDLE;
        end
        default: begin
          rtc_busy = 1'b0;
          ph       = PH_IDLE;
        end
      endcase
      lv.en   = pin_en;
      lv.sclk = pin_sclk;
      lv.dout = pin_drv ? pin_dat : 1'b0;
      lv.drv  = pin_drv;
      lv.done = done;
      lv.rv   = rv;
    end
  endtask

  // offer one transaction after a random gap, wait for it, then model it
  task automatic send_item(input opcode_t op, input logic [7:0] cmd,
                           input logic [7:0] wv, input logic din,
                           output bit produced, output bit took, output line_t lv);
    int gap;
    int r;
    gap = 0;
    if (!tx_calm) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(8, 30);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tuser  <= op;
    s_tdata  <= {7'b0, din, wv, cmd};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    advance_sequencer(op, cmd, wv, din, produced, took, lv);
  endtask

  // output side stalls: short random ones, a few long ones, calm stretches
  initial begin
    int r;
    int hold_left;
    int cyc;
    bit rx_calm;
    hold_left = 0;
    cyc       = 0;
    rx_calm   = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 128 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_calm) begin
        m_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          m_tready <= 1'b1;
        end else if (r < 95) begin
          m_tready <= 1'b0;
        end else begin
          hold_left = $urandom_range(5, 25);
          m_tready  <= 1'b0;
        end
      end
    end
  end

  // compare each output transaction with the oldest predicted line levels
  always @(posedge clk) begin
    line_t got;
    line_t want;
    if (!rst && m_tvalid && m_tready) begin
      // tdata: [0] enable, [1] clock, [2] data out, [3] drive, [11:4] read value
      got.en   = m_tdata[0];
      got.sclk = m_tdata[1];
      got.dout = m_tdata[2];
      got.drv  = m_tdata[3];
      got.rv   = m_tdata[11:4];
      got.done = m_tlast;
      if (pending_levels.size() == 0) begin
        report("result with nothing pending, tdata", m_tdata, 0);
      end else begin
        want = pending_levels.pop_front();
        if (got.en != want.en) report("enable_line", got.en, want.en);
        if (got.sclk != want.sclk) report("clock_line", got.sclk, want.sclk);
        if (got.dout != want.dout) report("data_out", got.dout, want.dout);
        if (got.drv != want.drv) report("data_drive", got.drv, want.drv);
        if (got.done != want.done) report("done", got.done, want.done);
        if (got.rv != want.rv) report("read_value", got.rv, want.rv);
      end
    end
  end

  // stimulus
  initial begin
    int         i;
    int         k;
    int         iter;
    int         n_rand;
    int         r;
    bit         produced;
    bit         took;
    line_t      lv;
    opcode_t    op;
    logic [7:0] cmd;
    logic [7:0] wv;
    logic       din;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (i = 0; i < N_ROWS; i++) begin
      for (k = 0; k < dir_rows[i].reps; k++) begin
        send_item(dir_rows[i].op, dir_rows[i].cmd, dir_rows[i].wv, dir_rows[i].din,
                  produced, took, lv);
        if (produced) pending_levels.push_back(dir_rows[i].fixed ? dir_rows[i].lv : lv);
      end
    end

    // random part: mostly whole transfers, some noise and stray starts
    iter   = 0;
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      if (iter % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      iter++;
      cmd = 8'($urandom);
      wv  = 8'($urandom);
      din = 1'($urandom);
      r   = $urandom_range(0, 99);
      if (!rtc_busy) begin
        if (r < 70) op = ($urandom_range(0, 1) == 1) ? OP_READ : OP_WRITE;
        else if (r < 74) op = OP_NONE;
        else op = OP_TICK;
      end else begin
        if (r < 2) op = ($urandom_range(0, 1) == 1) ? OP_READ : OP_WRITE;
        else if (r < 4) op = OP_NONE;
        else op = OP_TICK;
      end
      send_item(op, cmd, wv, din, produced, took, lv);
      if (produced) pending_levels.push_back(lv);
      if (took) begin
        n_rand++;
        // long receiver hold while the sender keeps offering
        if (n_rand == PRESSURE_AT) hold_req = 1'b1;
      end
    end
    s_tvalid <= 1'b0;

    // drain
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
